// ----- rtl/bbu_pkg.sv -----
package bbu_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_WINDOW_DEF = 11;

    localparam int SHARP_W = 8;
    localparam int IMG_W_W = 11;
    localparam int IMG_H_W = 13;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 2;
    localparam int HALF_W  = 3;
    localparam int TAP_W   = HALF_W + 1;
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;

    localparam logic [IDX_W-1:0] REG_SHARPNESS = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH     = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT    = 2'd2;

    localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SUM,
        ST_CENTER,
        ST_CWAIT,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic acc;
        logic start;
    } lane_ctrl_t;

    // Half window size from the raw sharpness byte, limited by the window limit.
    function automatic logic [HALF_W-1:0] half_window(input logic [SHARP_W-1:0] s,
                                                       input int max_window);
        logic signed [SHARP_W:0] sv;
        logic [6:0]              mag;
        logic [3:0]              q;
        logic [HALF_W:0]         hh;
        int                      lim;
        sv  = $signed({s[SHARP_W-1], s});
        mag = 7'd0;
        q   = 4'd0;
        lim = ((max_window % 2) == 0) ? (max_window - 1) / 2 : max_window / 2;
        if (sv < -9'sd100) begin
            mag = 7'd100;
        end else if (sv > 9'sd100) begin
            mag = 7'd100;
        end else if (sv < 0) begin
            mag = 7'(-sv);
        end else begin
            mag = 7'(sv);
        end
        for (int i = 1; i <= 10; i++) begin
            if (mag >= 7'(i * 10)) begin
                q = q + 4'd1;
            end
        end
        hh = (HALF_W + 1)'((5'(q) + 5'd1) >> 1);
        if (hh > (HALF_W + 1)'(lim)) begin
            hh = (HALF_W + 1)'(lim);
        end
        return hh[HALF_W-1:0];
    endfunction

    function automatic logic is_sharpen(input logic [SHARP_W-1:0] s);
        return s[SHARP_W-1];
    endfunction

endpackage

// ----- rtl/bbu_ram.sv -----
module bbu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/bbu_lane.sv -----
module bbu_lane #(
    parameter int SUM_W = 15,
    parameter int N2_W  = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bbu_pkg::lane_ctrl_t   ctrl,
    input  logic [7:0]            din,
    input  logic [N2_W-1:0]       n2,
    output logic [7:0]            mean,
    output logic                  done
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [N2_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [N2_W:0]    trial;

    // The accumulator doubles as the quotient shift register of the divider.
    always_comb begin
        sum_next  = sum_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, sum_reg[SUM_W-1]};
        if (ctrl.clear) begin
            sum_next = '0;
        end else if (ctrl.acc) begin
            sum_next = sum_reg + SUM_W'(din);
        end else if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_W);
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, n2}) begin
                rem_next = N2_W'(trial - {1'b0, n2});
                sum_next = {sum_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[N2_W-1:0];
                sum_next = {sum_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        sum_reg <= sum_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign mean = sum_reg[7:0];
    assign done = !busy_reg;

endmodule

// ----- rtl/box_blur_unsharp_rgb.sv -----
// Box blur / unsharp mask for RGB888 pixels in raster order. Each accepted
// request writes its pixel into a ring of MAX_WINDOW+2 line stores; when the
// window around the next output pixel is complete, three channel lanes sum the
// N x N window (edge pixels replicated) one tap per cycle from the line store
// read port, then divide by N squared with a bit-serial divider, and a merge
// stage forms the blurred mean or the sharpened 2*pixel - mean clamped to
// 0..255. A request that produces no result returns to idle after the check
// state; one that produces a result also passes through the window sum, the
// center read and the divider, paced by the single line store read port.
// Requests are taken one at a time; a finished result waits in an output
// register, so the next request is taken while the result is unclaimed. Drain
// requests (mode = 1) flush the outputs still pending at the frame end, and
// frame_end marks the last pixel of the frame. Any configuration write
// restarts the frame; write only while the block is idle.
module box_blur_unsharp_rgb #(
    parameter int MAX_WIDTH  = bbu_pkg::MAX_WIDTH_DEF,
    parameter int MAX_WINDOW = bbu_pkg::MAX_WINDOW_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [bbu_pkg::IDX_W-1:0] cfg_index,
    input  logic [bbu_pkg::CFG_W-1:0] cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_mode,
    input  logic [7:0]                s_red_in,
    input  logic [7:0]                s_green_in,
    input  logic [7:0]                s_blue_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [7:0]                m_red_out,
    output logic [7:0]                m_green_out,
    output logic [7:0]                m_blue_out,
    output logic                      m_frame_end
);

    localparam int RING   = MAX_WINDOW + 2;
    localparam int RING_W = $clog2(RING);
    localparam int DEPTH  = RING * MAX_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = bbu_pkg::IMG_H_W;
    localparam int SUM_W  = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int N2_W   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int HALF_W = bbu_pkg::HALF_W;
    localparam int TAP_W  = bbu_pkg::TAP_W;
    localparam int SW     = ROW_W + 2;

    // Configuration registers.
    logic [bbu_pkg::SHARP_W-1:0] sharpness_reg;
    logic [bbu_pkg::IMG_W_W-1:0] image_width_reg;
    logic [bbu_pkg::IMG_H_W-1:0] image_height_reg;

    // Frame position state.
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [RING_W-1:0] ring_reg, ring_next;
    logic [ROW_W-1:0]  orow_reg, orow_next;
    logic [COL_W-1:0]  ocol_reg, ocol_next;
    logic [RING_W-1:0] oring_reg, oring_next;

    logic signed [TAP_W-1:0] ty_reg, ty_next, tx_reg, tx_next;
    logic                    pend_reg, pend_next;
    logic [23:0]             center_reg, center_next;

    bbu_pkg::state_t state_reg, state_next;

    logic       mvalid_reg, mvalid_next;
    logic [7:0] mred_reg, mred_next, mgrn_reg, mgrn_next, mblu_reg, mblu_next;
    logic       mend_reg, mend_next;

    // Effective geometry and window.
    logic [COL_W-1:0]  eff_w;
    logic [ROW_W-1:0]  eff_h;
    logic [HALF_W-1:0] half;
    logic              sharpen;
    logic [N2_W-1:0]   n2;
    logic [3:0]        side;

    always_comb begin
        if (image_width_reg == '0) begin
            eff_w = COL_W'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            eff_w = COL_W'(MAX_WIDTH);
        end else begin
            eff_w = COL_W'(image_width_reg);
        end
        eff_h   = (image_height_reg == '0) ? ROW_W'(1) : image_height_reg;
        half    = bbu_pkg::half_window(sharpness_reg, MAX_WINDOW);
        sharpen = bbu_pkg::is_sharpen(sharpness_reg);
        side    = {half, 1'b1};
        n2      = N2_W'(8'(side) * 8'(side));
    end

    // Line store write side and the accept-cycle position update.
    logic              acc_fire;
    logic              bad_pos;
    logic [ROW_W-1:0]  row_b;
    logic [COL_W-1:0]  col_b;
    logic [RING_W-1:0] ring_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    assign acc_fire = s_valid && s_ready;

    always_comb begin
        bad_pos = (row_reg > eff_h) || (col_reg >= eff_w) ||
                  (orow_reg >= eff_h) || (ocol_reg >= eff_w);
        row_b   = bad_pos ? '0 : row_reg;
        col_b   = bad_pos ? '0 : col_reg;
        ring_b  = bad_pos ? '0 : ring_reg;
        wr_en   = acc_fire && !s_mode && (row_b < eff_h);
        wr_addr = ADDR_W'(ring_b) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_b);
    end

    // Tap address: clamped row and column, row mapped into the ring.
    logic signed [SW-1:0]  sy, sx, dy;
    logic [ROW_W-1:0]      ty_row;
    logic [COL_W-1:0]      tx_col;
    logic signed [RING_W+2:0] rsum;
    logic [RING_W-1:0]     tap_ring;
    logic [ADDR_W-1:0]     tap_addr, ctr_addr, rd_addr;

    always_comb begin
        sy = $signed({2'b00, orow_reg}) + SW'(ty_reg);
        sx = $signed(SW'({1'b0, ocol_reg})) + SW'(tx_reg);
        if (sy < 0) begin
            ty_row = '0;
        end else if (sy >= $signed({2'b00, eff_h})) begin
            ty_row = eff_h - ROW_W'(1);
        end else begin
            ty_row = sy[ROW_W-1:0];
        end
        if (sx < 0) begin
            tx_col = '0;
        end else if (sx >= $signed(SW'({1'b0, eff_w}))) begin
            tx_col = eff_w - COL_W'(1);
        end else begin
            tx_col = sx[COL_W-1:0];
        end
        dy   = $signed({2'b00, ty_row}) - $signed({2'b00, orow_reg});
        rsum = $signed((RING_W + 3)'({1'b0, oring_reg})) + (RING_W + 3)'(dy);
        if (rsum < 0) begin
            rsum = rsum + (RING_W + 3)'(RING);
        end else if (rsum >= (RING_W + 3)'(RING)) begin
            rsum = rsum - (RING_W + 3)'(RING);
        end
        tap_ring = rsum[RING_W-1:0];
        tap_addr = ADDR_W'(tap_ring) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tx_col);
        ctr_addr = ADDR_W'(oring_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ocol_reg);
        rd_addr  = (state_reg == bbu_pkg::ST_CENTER) ? ctr_addr : tap_addr;
    end

    logic [23:0] rd_data;

    bbu_ram #(
        .WIDTH(bbu_pkg::PIX_W),
        .DEPTH(DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({s_red_in, s_green_in, s_blue_in}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Readiness of the next output pixel.
    logic [ROW_W:0] need_r;
    logic [COL_W:0] need_c;
    logic           out_ready;
    logic           last_tap;
    logic           last_pix;
    logic           lanes_done;
    logic           slot_free;

    always_comb begin
        need_r = {1'b0, orow_reg} + (ROW_W + 1)'(half);
        if (need_r > (ROW_W + 1)'(eff_h - ROW_W'(1))) begin
            need_r = (ROW_W + 1)'(eff_h - ROW_W'(1));
        end
        need_c = {1'b0, ocol_reg} + (COL_W + 1)'(half);
        if (need_c > (COL_W + 1)'(eff_w - COL_W'(1))) begin
            need_c = (COL_W + 1)'(eff_w - COL_W'(1));
        end
        out_ready = (row_reg >= eff_h) || ((ROW_W + 1)'(row_reg) > need_r) ||
                    (((ROW_W + 1)'(row_reg) == need_r) &&
                     ((COL_W + 1)'(col_reg) > need_c));
        last_tap  = (ty_reg == $signed(TAP_W'(half))) && (tx_reg == $signed(TAP_W'(half)));
        last_pix  = (orow_reg == eff_h - ROW_W'(1)) && (ocol_reg == eff_w - COL_W'(1));
        slot_free = !mvalid_reg || m_ready;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bbu_pkg::ST_IDLE: begin
                if (acc_fire) begin
                    state_next = bbu_pkg::ST_CHECK;
                end
            end
            bbu_pkg::ST_CHECK: begin
                state_next = out_ready ? bbu_pkg::ST_SUM : bbu_pkg::ST_IDLE;
            end
            bbu_pkg::ST_SUM: begin
                if (last_tap) begin
                    state_next = bbu_pkg::ST_CENTER;
                end
            end
            bbu_pkg::ST_CENTER: state_next = bbu_pkg::ST_CWAIT;
            bbu_pkg::ST_CWAIT:  state_next = bbu_pkg::ST_DIV;
            bbu_pkg::ST_DIV: begin
                if (lanes_done) begin
                    state_next = bbu_pkg::ST_FINISH;
                end
            end
            bbu_pkg::ST_FINISH: begin
                if (slot_free) begin
                    state_next = bbu_pkg::ST_IDLE;
                end
            end
            default: state_next = bbu_pkg::ST_IDLE;
        endcase
    end

    // Lane control and handshake outputs.
    bbu_pkg::lane_ctrl_t lane_ctrl;

    always_comb begin
        lane_ctrl = '0;
        s_ready   = 1'b0;
        case (state_reg)
            bbu_pkg::ST_IDLE:   s_ready = 1'b1;
            bbu_pkg::ST_CHECK:  lane_ctrl.clear = out_ready;
            bbu_pkg::ST_SUM:    lane_ctrl.acc = pend_reg;
            bbu_pkg::ST_CENTER: lane_ctrl.acc = pend_reg;
            bbu_pkg::ST_CWAIT:  lane_ctrl.start = 1'b1;
            default: begin
                lane_ctrl = '0;
            end
        endcase
    end

    // Three channel lanes.
    logic [7:0] mean_r, mean_g, mean_b;
    logic       done_r, done_g, done_b;

    bbu_lane #(.SUM_W(SUM_W), .N2_W(N2_W)) u_lane_r (
        .aclk(aclk), .aresetn(aresetn), .ctrl(lane_ctrl), .din(rd_data[23:16]),
        .n2(n2), .mean(mean_r), .done(done_r)
    );
    bbu_lane #(.SUM_W(SUM_W), .N2_W(N2_W)) u_lane_g (
        .aclk(aclk), .aresetn(aresetn), .ctrl(lane_ctrl), .din(rd_data[15:8]),
        .n2(n2), .mean(mean_g), .done(done_g)
    );
    bbu_lane #(.SUM_W(SUM_W), .N2_W(N2_W)) u_lane_b (
        .aclk(aclk), .aresetn(aresetn), .ctrl(lane_ctrl), .din(rd_data[7:0]),
        .n2(n2), .mean(mean_b), .done(done_b)
    );

    assign lanes_done = done_r && done_g && done_b;

    // Merge stage: blurred mean, or sharpened 2*pixel - mean with clamping.
    function automatic logic [7:0] merge_ch(input logic [7:0] c, input logic [7:0] m,
                                            input logic sh);
        logic signed [10:0] v;
        v = $signed({2'b00, c, 1'b0}) - $signed({3'b000, m});
        if (!sh) begin
            return m;
        end else if (v < 0) begin
            return 8'd0;
        end else if (v > 11'sd255) begin
            return 8'hFF;
        end else begin
            return v[7:0];
        end
    endfunction

    // Datapath next values.
    always_comb begin
        row_next    = row_reg;
        col_next    = col_reg;
        ring_next   = ring_reg;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;
        oring_next  = oring_reg;
        ty_next     = ty_reg;
        tx_next     = tx_reg;
        pend_next   = 1'b0;
        center_next = center_reg;
        mvalid_next = mvalid_reg && !m_ready;
        mred_next   = mred_reg;
        mgrn_next   = mgrn_reg;
        mblu_next   = mblu_reg;
        mend_next   = mend_reg;

        case (state_reg)
            bbu_pkg::ST_IDLE: begin
                if (acc_fire) begin
                    row_next   = row_b;
                    col_next   = col_b;
                    ring_next  = ring_b;
                    if (bad_pos) begin
                        orow_next  = '0;
                        ocol_next  = '0;
                        oring_next = '0;
                    end
                    if (wr_en) begin
                        if (col_b + COL_W'(1) >= eff_w) begin
                            col_next  = '0;
                            row_next  = row_b + ROW_W'(1);
                            ring_next = (ring_b == RING_W'(RING - 1)) ? '0
                                      : ring_b + RING_W'(1);
                        end else begin
                            col_next = col_b + COL_W'(1);
                        end
                    end
                end
            end
            bbu_pkg::ST_CHECK: begin
                ty_next = -$signed(TAP_W'(half));
                tx_next = -$signed(TAP_W'(half));
            end
            bbu_pkg::ST_SUM: begin
                pend_next = 1'b1;
                if (tx_reg == $signed(TAP_W'(half))) begin
                    tx_next = -$signed(TAP_W'(half));
                    ty_next = ty_reg + TAP_W'(1);
                end else begin
                    tx_next = tx_reg + TAP_W'(1);
                end
            end
            bbu_pkg::ST_CWAIT: begin
                center_next = rd_data;
            end
            bbu_pkg::ST_FINISH: begin
                if (slot_free) begin
                    mvalid_next = 1'b1;
                    mred_next   = merge_ch(center_reg[23:16], mean_r, sharpen);
                    mgrn_next   = merge_ch(center_reg[15:8], mean_g, sharpen);
                    mblu_next   = merge_ch(center_reg[7:0], mean_b, sharpen);
                    mend_next   = last_pix;
                    if (last_pix) begin
                        row_next   = '0;
                        col_next   = '0;
                        ring_next  = '0;
                        orow_next  = '0;
                        ocol_next  = '0;
                        oring_next = '0;
                    end else if (ocol_reg + COL_W'(1) >= eff_w) begin
                        ocol_next  = '0;
                        orow_next  = orow_reg + ROW_W'(1);
                        oring_next = (oring_reg == RING_W'(RING - 1)) ? '0
                                   : oring_reg + RING_W'(1);
                    end else begin
                        ocol_next = ocol_reg + COL_W'(1);
                    end
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= bbu_pkg::ST_IDLE;
            sharpness_reg    <= '0;
            image_width_reg  <= bbu_pkg::WIDTH_RESET;
            image_height_reg <= bbu_pkg::HEIGHT_RESET;
            row_reg          <= '0;
            col_reg          <= '0;
            ring_reg         <= '0;
            orow_reg         <= '0;
            ocol_reg         <= '0;
            oring_reg        <= '0;
            pend_reg         <= 1'b0;
            mvalid_reg       <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we) begin
                // Every write restarts the frame, whatever the index.
                case (cfg_index)
                    bbu_pkg::REG_SHARPNESS: sharpness_reg <= cfg_data[bbu_pkg::SHARP_W-1:0];
                    bbu_pkg::REG_WIDTH:     image_width_reg <= cfg_data[bbu_pkg::IMG_W_W-1:0];
                    bbu_pkg::REG_HEIGHT:    image_height_reg <= cfg_data;
                    default: begin
                        sharpness_reg <= sharpness_reg;
                    end
                endcase
                row_reg   <= '0;
                col_reg   <= '0;
                ring_reg  <= '0;
                orow_reg  <= '0;
                ocol_reg  <= '0;
                oring_reg <= '0;
            end else begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                ring_reg  <= ring_next;
                orow_reg  <= orow_next;
                ocol_reg  <= ocol_next;
                oring_reg <= oring_next;
            end
        end
        ty_reg     <= ty_next;
        tx_reg     <= tx_next;
        center_reg <= center_next;
        mred_reg   <= mred_next;
        mgrn_reg   <= mgrn_next;
        mblu_reg   <= mblu_next;
        mend_reg   <= mend_next;
    end

    assign m_valid     = mvalid_reg;
    assign m_red_out   = mred_reg;
    assign m_green_out = mgrn_reg;
    assign m_blue_out  = mblu_reg;
    assign m_frame_end = mend_reg;

endmodule

// ----- tb/sv/box_blur_unsharp_rgb_checker.sv -----
`timescale 1ns / 100ps

module box_blur_unsharp_rgb_checker
    import bbu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic             s_mode,
    input  logic [7:0]       s_red_in,
    input  logic [7:0]       s_green_in,
    input  logic [7:0]       s_blue_in,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [7:0]       m_red_out,
    input  logic [7:0]       m_green_out,
    input  logic [7:0]       m_blue_out,
    input  logic             m_frame_end,
    output int               errors,
    output int               pending
);

    localparam int LINE_LEN  = 1024;
    localparam int RING_ROWS = 13;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } pixel_out_t;

    pixel_out_t filtered_q[$];

    logic [PIX_W-1:0]   ring_lines [0:RING_ROWS*LINE_LEN-1];
    logic [SHARP_W-1:0] sharp_reg;
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    int in_row, in_col, out_row, out_col;

    assign pending = filtered_q.size();

    function automatic int clip(input int v, input int size);
        if (v < 0) return 0;
        if (v >= size) return size - 1;
        return v;
    endfunction

    // Filter one accepted request and queue the pixel it releases, if any.
    task automatic filter_request(input logic mode, input logic [23:0] px);
        int w, hg, s, n, h, n2, need_r, need_c, y, mean, v;
        int sum [3];
        logic [23:0] tap, center;
        logic sharpen, ready;
        pixel_out_t res;
        w  = (width_reg == 0) ? 1 : ((width_reg > LINE_LEN) ? LINE_LEN : int'(width_reg));
        hg = (height_reg == 0) ? 1 : int'(height_reg);
        s  = $signed(sharp_reg);
        if (s < -100) s = -100;
        if (s > 100) s = 100;
        sharpen = s < 0;
        if (s < 0) s = -s;
        n = s / 10 + 1;
        if (n % 2 == 0) n++;
        if (n > 11) n = 11;
        h  = n / 2;
        n2 = n * n;
        if (in_row > hg || in_col >= w || out_row >= hg || out_col >= w) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        end
        if (!mode && in_row < hg) begin
            ring_lines[(in_row % RING_ROWS) * LINE_LEN + in_col] = px;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        need_r = (out_row + h > hg - 1) ? hg - 1 : out_row + h;
        need_c = (out_col + h > w - 1) ? w - 1 : out_col + h;
        ready = in_row >= hg || in_row > need_r || (in_row == need_r && in_col > need_c);
        if (!ready) return;
        sum[0] = 0; sum[1] = 0; sum[2] = 0;
        for (int dy = -h; dy <= h; dy++) begin
            y = clip(out_row + dy, hg) % RING_ROWS;
            for (int dx = -h; dx <= h; dx++) begin
                tap = ring_lines[y * LINE_LEN + clip(out_col + dx, w)];
                sum[0] += tap[23:16];
                sum[1] += tap[15:8];
                sum[2] += tap[7:0];
            end
        end
        center = ring_lines[(out_row % RING_ROWS) * LINE_LEN + out_col];
        for (int k = 0; k < 3; k++) begin
            mean = sum[k] / n2;
            if (sharpen) begin
                v = 2 * int'(center[23 - 8 * k -: 8]) - mean;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end else begin
                v = mean;
            end
            case (k)
                0: res.red = v[7:0];
                1: res.green = v[7:0];
                default: res.blue = v[7:0];
            endcase
        end
        res.frame_end = (out_row == hg - 1) && (out_col == w - 1);
        filtered_q.push_back(res);
        if (res.frame_end) begin
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    always @(posedge aclk) begin
        pixel_out_t exp_px;
        if (!aresetn) begin
            sharp_reg  = '0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            filtered_q.delete();
            errors = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SHARPNESS: sharp_reg = cfg_data[SHARP_W-1:0];
                    REG_WIDTH:     width_reg = cfg_data[IMG_W_W-1:0];
                    REG_HEIGHT:    height_reg = cfg_data[IMG_H_W-1:0];
                    default: ;
                endcase
                in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            end
            // The result side is checked before the request side so that an
            // expectation made at this edge is never compared at this edge.
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result with nothing expected: %h %h %h fe=%b",
                                 m_red_out, m_green_out, m_blue_out, m_frame_end);
                end else begin
                    exp_px = filtered_q.pop_front();
                    if (m_red_out !== exp_px.red || m_green_out !== exp_px.green ||
                        m_blue_out !== exp_px.blue || m_frame_end !== exp_px.frame_end) begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: expected %h %h %h fe=%b, got %h %h %h fe=%b",
                                     exp_px.red, exp_px.green, exp_px.blue,
                                     exp_px.frame_end, m_red_out, m_green_out,
                                     m_blue_out, m_frame_end);
                    end
                end
            end
            if (s_valid && s_ready)
                filter_request(s_mode, {s_red_in, s_green_in, s_blue_in});
        end
    end

endmodule

// ----- tb/sv/box_blur_unsharp_rgb_tb.sv -----
`timescale 1ns / 100ps

module box_blur_unsharp_rgb_tb;
    import bbu_pkg::*;

    // Index 3 is not a register, but a write to it still restarts the frame.
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 6000000;
    // A request that releases no pixel may still keep the block busy a while;
    // this covers the longest window computation with margin.
    localparam int SETTLE_CYCLES = 300;

    logic             aclk;
    logic             aresetn;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             s_valid;
    logic             s_ready;
    logic             s_mode;
    logic [7:0]       s_red_in, s_green_in, s_blue_in;
    logic             m_valid;
    logic             m_ready;
    logic [7:0]       m_red_out, m_green_out, m_blue_out;
    logic             m_frame_end;
    int               errors;
    int               pending;
    int               cycles;
    int               random_reqs;
    bit               hold_now;

    box_blur_unsharp_rgb DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_red_in(s_red_in), .s_green_in(s_green_in), .s_blue_in(s_blue_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_out(m_red_out), .m_green_out(m_green_out), .m_blue_out(m_blue_out),
        .m_frame_end(m_frame_end)
    );

    box_blur_unsharp_rgb_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode),
        .s_red_in(s_red_in), .s_green_in(s_green_in), .s_blue_in(s_blue_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red_out(m_red_out), .m_green_out(m_green_out), .m_blue_out(m_blue_out),
        .m_frame_end(m_frame_end), .errors(errors), .pending(pending)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return 0;
        if (pick < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Channel values lean toward the extremes so the sharpen clamp is hit often.
    function automatic logic [7:0] chan_value();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Result side: bursts of ready separated by stalls, with one long hold-off
    // during the tall frame so the block fills up and backs up its request port.
    initial begin
        bit held;
        held = 1'b0;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 200 : 8)) @(posedge aclk);
            m_ready <= 1'b0;
            if (!held && hold_now) begin
                held = 1'b1;
                repeat (3000) @(posedge aclk);
            end else begin
                repeat (gap_len() + 1) @(posedge aclk);
            end
        end
    end

    // Offers one request and holds it until the block takes it. Valid is only
    // lowered when a gap follows, so it never gets two updates in one step.
    task automatic send_request(input logic mode, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Waits until every expected pixel has come out and the block has gone quiet.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    // Runs one frame: configure, stream the pixels (with stray drains mixed in),
    // then drain until the last pixel is out. A truncated frame stops early and
    // leaves its pending pixels to be thrown away by the next register write.
    task automatic run_frame(input logic [7:0] sharp, input logic [10:0] width,
                             input logic [12:0] height, input bit truncate,
                             input bit spare_write);
        int eff_w, eff_h, total, sent, drains;
        eff_w = (width == 0) ? 1 : ((width > 1024) ? 1024 : int'(width));
        eff_h = (height == 0) ? 1 : int'(height);
        total = eff_w * eff_h;
        if (truncate) total = $urandom_range(total);
        write_reg(REG_SHARPNESS, CFG_W'(sharp));
        write_reg(REG_WIDTH, CFG_W'(width));
        write_reg(REG_HEIGHT, CFG_W'(height));
        if (spare_write) write_reg(REG_SPARE, CFG_W'($urandom));
        cfg_we <= 1'b0;
        sent = 0;
        while (sent < total) begin
            if ($urandom_range(19) == 0) begin
                send_request(1'b1, chan_value(), chan_value(), chan_value());
            end else begin
                send_request(1'b0, chan_value(), chan_value(), chan_value());
                sent++;
            end
            random_reqs++;
        end
        if (!truncate) begin
            // Enough drains to flush the widest window; drains past the frame end release nothing.
            // Some are pixels: dropped before the frame end, after it they start a new frame.
            drains = ((6 * eff_w + 6) < total ? 6 * eff_w + 6 : total) + 2;
            repeat (drains) begin
                send_request($urandom_range(4) != 0, chan_value(), chan_value(),
                             chan_value());
                random_reqs++;
            end
        end
        wait_idle();
    endtask

    initial begin
        logic [7:0] sharp;
        cycles      = 0;
        random_reqs = 0;
        hold_now    = 1'b0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_mode      = 1'b0;
        s_red_in    = '0;
        s_green_in  = '0;
        s_blue_in   = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames: pass-through, both signs at full strength, the
        // out-of-range sharpness codes, zero width and height, and a spare write.
        run_frame(8'd0, 11'd1, 13'd1, 1'b0, 1'b0);
        run_frame(8'd100, 11'd4, 13'd3, 1'b0, 1'b0);
        run_frame(8'(-100), 11'd5, 13'd4, 1'b0, 1'b1);
        run_frame(8'd127, 11'd3, 13'd2, 1'b0, 1'b0);
        run_frame(8'h80, 11'd2, 13'd3, 1'b0, 1'b0);
        run_frame(8'd25, 11'd0, 13'd0, 1'b0, 1'b0);

        // A tall narrow frame at the largest sharpen window, so the line ring
        // wraps several times; the result side holds off once during it.
        hold_now = 1'b1;
        run_frame(8'(-100), 11'd2, 13'd40, 1'b0, 1'b0);

        // Random frames, small so the window edges dominate; a few are cut short.
        random_reqs = 0;
        while (random_reqs < 600) begin
            if ($urandom_range(9) == 0) sharp = 8'($urandom);
            else sharp = 8'($signed($urandom_range(200)) - 100);
            run_frame(sharp, 11'($urandom_range(1, 14)), 13'($urandom_range(1, 8)),
                      $urandom_range(7) == 0, $urandom_range(9) == 0);
        end

        wait_idle();
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
